@@ src/ila_pkg.sv @@
// Shared types and constants for the indexed list with insert and remove.
package ila_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_REMOVE = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast command to every cell of the chain
  typedef struct packed {
    logic load;        // cell at the selected index takes word_in
    logic shift_up;    // cells above the selected index take the lower neighbor
    logic shift_down;  // cells at or above the selected index take the upper neighbor
  } cell_ctrl_t;

endpackage

@@ src/ila_cell.sv @@
// One storage cell of the list: holds a word and trades it with its neighbors.
module ila_cell
  import ila_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 4
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]         sel,
  input  logic signed [WORD_W-1:0] word_in,
  input  logic signed [WORD_W-1:0] lower,
  input  logic signed [WORD_W-1:0] upper,
  output logic signed [WORD_W-1:0] word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [WORD_W-1:0] word_next;

  // choose the next word from the broadcast command
  always_comb begin
    word_next = word;
    if (ctrl.load && (MY_IDX == sel)) begin
      word_next = word_in;
    end else if (ctrl.shift_up && (MY_IDX > sel)) begin
      word_next = lower;
    end else if (ctrl.shift_down && (MY_IDX >= sel)) begin
      word_next = upper;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

@@ src/indexed_list_insert_remove.sv @@
// Top level: indexed list of signed words built as a chain of storage cells.
//
// Use: requests arrive on the s_axis channel (read, overwrite, append,
// insert at index, remove at index); one result beat per request leaves on
// m_axis carrying the word read or removed, the new entry count and a status
// (ok, index out of range, list full).
// The result beat of an accepted request is registered and shows from the
// cycle after acceptance on. Throughput: one request per cycle while the
// receiver does not stall. Every cell loads its new word in parallel in the
// accepting cycle, so an insert or remove moves the whole tail at once.
// The result sits in an output register; a new request is taken whenever
// that register is empty or is being drained in the same cycle, so a
// stalled receiver holds the result and stops input only while it stays
// full.
// Reset (rst, synchronous) empties the list and drops any pending result.
// Cell contents are not cleared; only entries below the count are ever read.
module indexed_list_insert_remove
  import ila_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] action, [6:3] position, [38:7] word_in, [39] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] word_out, [36:32] count, [38:37] status, [39] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned XW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // request fields
  action_t                  action;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] word_in;

  assign action   = action_t'(s_axis_tdata[ACTION_W-1:0]);
  assign position = s_axis_tdata[ACTION_W +: POS_W];
  assign word_in  = s_axis_tdata[ACTION_W+POS_W +: WORD_W];

  // list state
  logic [CW-1:0]            used;
  logic [CW-1:0]            used_next;
  logic signed [WORD_W-1:0] cells [CAPACITY];

  // output register
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_word;
  logic [COUNT_W-1:0]       out_count;
  status_t                  out_status;

  logic accept;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // index checks
  logic [CMPW-1:0]  pos_x;
  logic [CMPW-1:0]  used_x;
  logic             in_range;
  logic             full;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] used_idx;

  assign pos_x    = CMPW'(position);
  assign used_x   = CMPW'(used);
  assign in_range = pos_x < used_x;
  assign full     = used >= CAP_C;
  assign pos_idx  = pos_x[IDX_W-1:0];
  assign used_idx = used_x[IDX_W-1:0];

  // decode the request into a cell command and a result
  cell_ctrl_t               ctrl;
  logic [IDX_W-1:0]         sel;
  logic signed [WORD_W-1:0] res_word;
  status_t                  res_status;
  logic [XW-1:0]            used_wide;

  always_comb begin
    ctrl       = '0;
    sel        = pos_idx;
    res_word   = '0;
    res_status = ST_OK;
    used_next  = used;
    unique case (action)
      ACT_READ: begin
        if (in_range) res_word = cells[pos_idx];
        else res_status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (in_range) ctrl.load = 1'b1;
        else res_status = ST_RANGE;
      end
      ACT_APPEND: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.load = 1'b1;
          sel       = used_idx;
          used_next = used + CW'(1);
        end
      end
      ACT_INSERT: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.load     = 1'b1;
          ctrl.shift_up = 1'b1;
          used_next     = used + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else begin
          res_word        = cells[pos_idx];
          ctrl.shift_down = 1'b1;
          used_next       = used - CW'(1);
        end
      end
      default: ;
    endcase
    if (!accept) ctrl = '0;
  end

  assign used_wide = XW'(used_next);

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] lower;
    logic signed [WORD_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = cells[i];
    end else begin : g_mid_lo
      assign lower = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cells[i];
    end else begin : g_mid_hi
      assign upper = cells[i+1];
    end
    ila_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .sel     (sel),
      .word_in (word_in),
      .lower   (lower),
      .upper   (upper),
      .word    (cells[i])
    );
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) used <= used_next;
      if (accept) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word   <= res_word;
      out_count  <= used_wide[COUNT_W-1:0];
      out_status <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_status, out_count, out_word};

endmodule

@@ test/list_result_checker.sv @@
// Checker for the indexed list: predicts each result beat and compares it with the DUT.
module list_result_checker
  import ila_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // [2:0] action, [6:3] position, [38:7] word_in, [39] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] word_out, [36:32] count, [38:37] status, [39] zero
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    awaited,
  output int                    list_len
);

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } list_reply_t;

  // Shadow copy of the list
  logic [WORD_W-1:0] model_words [CAPACITY];
  int unsigned       model_used = 0;
  list_reply_t       awaited_replies [$];
  int                mismatches = 0;

  // Published copies, updated after the edge so readers never race the update
  int errors_q   = 0;
  int awaited_q  = 0;
  int list_len_q = 0;

  assign errors   = errors_q;
  assign awaited  = awaited_q;
  assign list_len = list_len_q;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH %s: got 0x%08h, want 0x%08h", what, got, want);
    mismatches++;
  endtask

  // Apply one request to the shadow list and return the reply it should produce
  function automatic list_reply_t apply_request(input logic [ACTION_W-1:0] act,
                                                input logic [POS_W-1:0]    pos,
                                                input logic [WORD_W-1:0]   val);
    list_reply_t reply;
    logic        hit;
    int unsigned k;
    reply.word   = '0;
    reply.status = ST_OK;
    hit = (pos < model_used);
    case (act)
      ACT_READ: begin
        if (hit) reply.word = model_words[pos];
        else reply.status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (hit) model_words[pos] = val;
        else reply.status = ST_RANGE;
      end
      ACT_APPEND: begin
        if (model_used >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          model_words[model_used] = val;
          model_used++;
        end
      end
      ACT_INSERT: begin
        // index check takes priority over the full check
        if (!hit) begin
          reply.status = ST_RANGE;
        end else if (model_used >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          for (k = model_used; k > pos; k--) model_words[k] = model_words[k-1];
          model_words[pos] = val;
          model_used++;
        end
      end
      ACT_REMOVE: begin
        if (!hit) begin
          reply.status = ST_RANGE;
        end else begin
          reply.word = model_words[pos];
          for (k = pos; k + 1 < model_used; k++) model_words[k] = model_words[k+1];
          model_used--;
        end
      end
      default: ;  // spare codes: no change, zero word, ok status
    endcase
    reply.count = model_used[COUNT_W-1:0];
    return reply;
  endfunction

  // Retire result beats first, then queue the prediction for a new request
  always @(posedge clk) begin
    list_reply_t want;
    if (rst) begin
      awaited_replies.delete();
      model_used = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result beat with nothing awaited", m_tdata[WORD_W-1:0], '0);
        end else begin
          want = awaited_replies.pop_front();
          if (m_tdata[WORD_W-1:0] !== want.word)
            report_mismatch("word_out", m_tdata[WORD_W-1:0], want.word);
          if (m_tdata[WORD_W +: COUNT_W] !== want.count)
            report_mismatch("count", WORD_W'(m_tdata[WORD_W +: COUNT_W]), WORD_W'(want.count));
          if (m_tdata[WORD_W+COUNT_W +: STATUS_W] !== want.status)
            report_mismatch("status", WORD_W'(m_tdata[WORD_W+COUNT_W +: STATUS_W]),
                            WORD_W'(want.status));
          if (m_tdata[OUT_DATA_W-1] !== 1'b0)
            report_mismatch("pad bit", WORD_W'(m_tdata[OUT_DATA_W-1]), '0);
        end
      end
      if (s_tvalid && s_tready)
        awaited_replies.push_back(apply_request(s_tdata[ACTION_W-1:0],
                                                s_tdata[ACTION_W +: POS_W],
                                                s_tdata[ACTION_W+POS_W +: WORD_W]));
    end
    errors_q   <= mismatches;
    awaited_q  <= awaited_replies.size();
    list_len_q <= model_used;
  end

endmodule

@@ test/indexed_list_insert_remove_tb.sv @@
// Testbench top for the indexed list: drives requests and result stalls, gives the verdict.
module indexed_list_insert_remove_tb;
  import ila_pkg::*;

  localparam int unsigned CAPACITY  = 16;
  localparam int          ITEMS     = 1850;
  localparam int          HOLD_AT   = 500;   // cycle of the long receiver hold-off
  localparam int          HOLD_LEN  = 120;
  localparam int          IDLE_MAX  = 2000;  // cycles without any beat before giving up
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef enum int {BIAS_MIXED, BIAS_GROW, BIAS_SHRINK} fill_bias_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [2:0] action, [6:3] position, [38:7] word_in, [39] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] word_out, [36:32] count, [38:37] status, [39] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int errors;
  int awaited;
  int list_len;
  int burst_left = 0;
  int rx_cycle   = 0;
  int rx_mode    = 0;
  int idle_run   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_list_insert_remove #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  list_result_checker #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .errors   (errors),
    .awaited  (awaited),
    .list_len (list_len)
  );

  // Offer one request and hold it until accepted; gaps come between bursts
  task automatic push_request(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] val);
    int gap;
    s_axis_tdata  <= {1'b0, val, pos, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: randomly chosen stall patterns, plus one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    end
    if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= rx_cycle[0];
      endcase
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= IDLE_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    fill_bias_t            bias;
    int                    bias_left;
    int                    placed;
    int                    roll;
    int                    w_app, w_ins, w_rem, w_rd;
    logic [ACTION_W-1:0]   act;
    logic [POS_W-1:0]      pos;
    logic [WORD_W-1:0]     val;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 24);

    // Directed: empty list, extremes, boundary index, spare codes, full list
    push_request(ACT_READ,   4'd0, 32'h0000_0000);
    push_request(ACT_REMOVE, 4'd0, 32'h0000_0000);
    push_request(ACT_INSERT, 4'd0, 32'h1234_5678);
    push_request(ACT_APPEND, 4'd15, 32'h8000_0000);
    push_request(ACT_APPEND, 4'd0, 32'h7FFF_FFFF);
    push_request(ACT_INSERT, 4'd1, 32'h0000_0000);
    push_request(ACT_INSERT, 4'd3, 32'hDEAD_BEEF);  // index equal to count
    push_request(ACT_WRITE,  4'd0, 32'hFFFF_FFFF);
    push_request(ACT_WRITE,  4'd15, 32'h5555_5555);
    push_request(ACT_READ,   4'd2, 32'h0000_0000);
    push_request(ACT_REMOVE, 4'd1, 32'h0000_0000);
    push_request(ACT_SPARE_FIRST,        4'd15, 32'hFFFF_FFFF);
    push_request(ACT_SPARE_FIRST + 3'd1, 4'd7, 32'hAAAA_AAAA);
    push_request(ACT_SPARE_LAST,         4'd0, 32'h0000_0001);
    for (int i = 0; i < CAPACITY - 2; i++)
      push_request(ACT_APPEND, 4'(i), 32'hA5A5_0000 | i);
    push_request(ACT_APPEND, 4'd0, 32'h0BAD_F00D);   // full
    push_request(ACT_INSERT, 4'd15, 32'h0BAD_F00D);  // full, index valid
    push_request(ACT_READ,   4'd15, 32'h0000_0000);
    push_request(ACT_REMOVE, 4'd15, 32'h0000_0000);
    push_request(ACT_REMOVE, 4'd0, 32'h0000_0000);

    // Random: phases that favor growing, shrinking or a mix
    placed    = 0;
    bias      = BIAS_MIXED;
    bias_left = 0;
    while (placed < ITEMS) begin
      if (bias_left <= 0) begin
        bias      = fill_bias_t'($urandom_range(0, 2));
        bias_left = $urandom_range(30, 60);
      end
      bias_left--;
      case (bias)
        BIAS_GROW: begin
          w_app = 35; w_ins = 30; w_rem = 10; w_rd = 10;
        end
        BIAS_SHRINK: begin
          w_app = 10; w_ins = 10; w_rem = 45; w_rd = 15;
        end
        default: begin
          w_app = 20; w_ins = 20; w_rem = 20; w_rd = 17;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < w_app) act = ACT_APPEND;
      else if (roll < w_app + w_ins) act = ACT_INSERT;
      else if (roll < w_app + w_ins + w_rem) act = ACT_REMOVE;
      else if (roll < w_app + w_ins + w_rem + w_rd) act = ACT_READ;
      else if (roll < 96) act = ACT_WRITE;
      else act = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));

      // mostly an index up to the current length, sometimes anywhere
      if ($urandom_range(0, 9) < 8)
        pos = (list_len >= 15) ? POS_W'($urandom_range(0, 15))
                               : POS_W'($urandom_range(0, list_len));
      else
        pos = POS_W'($urandom_range(0, 15));

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7FFF_FFFF;
          2: val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end else begin
        val = $urandom;
      end

      push_request(act, pos, val);
      if (act <= ACT_REMOVE) placed++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then let the bench settle
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && awaited == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
